>>> src/dspm_pkg.sv
// ----------------------------------------------------------------------------
// dspm_pkg
// shared types and constants of the dot-star pattern matcher
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dspm_pkg;

  localparam int unsigned PatternMaxDef = 32;
  localparam int unsigned ActionW       = 2;
  localparam int unsigned TokenIndexW   = 5;
  localparam int unsigned ByteW         = 8;

  typedef enum logic [ActionW-1:0] {
    ACT_LOAD = 2'd0,
    ACT_BYTE = 2'd1,
    ACT_END  = 2'd2
  } action_e;

  typedef struct packed {
    logic load;
    logic advance;
    logic finish;
  } cmd_t;

endpackage

>>> src/dspm_token_store.sv
// ----------------------------------------------------------------------------
// dspm_token_store
// pattern token registers and pattern length, written one token per load item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dspm_token_store import dspm_pkg::*; #(
  parameter int unsigned PatternMax = PatternMaxDef,
  localparam int unsigned LenW      = $clog2(PatternMax + 1)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  cmd_t                               cmd_i,
  input  logic [TokenIndexW-1:0]             token_index_i,
  input  logic [ByteW-1:0]                   token_byte_i,
  input  logic                               token_any_i,
  input  logic                               token_star_i,
  input  logic                               token_final_i,
  output logic [PatternMax-1:0][ByteW-1:0]   tok_byte_o,
  output logic [PatternMax-1:0]              tok_any_o,
  output logic [PatternMax-1:0]              tok_star_o,
  output logic [LenW-1:0]                    pat_len_o
);

  logic [PatternMax-1:0][ByteW-1:0] tok_byte_q;
  logic [PatternMax-1:0]            tok_any_q;
  logic [PatternMax-1:0]            tok_star_q;
  logic [LenW-1:0]                  pat_len_q, pat_len_d;
  logic                             in_range;

  assign in_range = 32'(token_index_i) < 32'(PatternMax);

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < PatternMax; j++) begin
      if (cmd_i.load && (32'(token_index_i) == 32'(j))) begin
        tok_byte_q[j] <= token_byte_i;
        tok_any_q[j]  <= token_any_i;
        tok_star_q[j] <= token_star_i;
      end
    end
  end

  always_comb begin
    pat_len_d = pat_len_q;
    if (cmd_i.load && in_range && token_final_i) begin
      pat_len_d = LenW'(32'(token_index_i) + 32'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q <= '0;
    end else begin
      pat_len_q <= pat_len_d;
    end
  end

  assign tok_byte_o = tok_byte_q;
  assign tok_any_o  = tok_any_q;
  assign tok_star_o = tok_star_q;
  assign pat_len_o  = pat_len_q;

endmodule

>>> src/dspm_advance.sv
// ----------------------------------------------------------------------------
// dspm_advance
// active-position vector with star closure, byte step and verdict
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dspm_advance import dspm_pkg::*; #(
  parameter int unsigned PatternMax = PatternMaxDef,
  localparam int unsigned LenW      = $clog2(PatternMax + 1),
  localparam int unsigned PosN      = PatternMax + 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  cmd_t                               cmd_i,
  input  logic [ByteW-1:0]                   subject_byte_i,
  input  logic [PatternMax-1:0][ByteW-1:0]   tok_byte_i,
  input  logic [PatternMax-1:0]              tok_any_i,
  input  logic [PatternMax-1:0]              tok_star_i,
  input  logic [LenW-1:0]                    pat_len_i,
  output logic                               verdict_o
);

  logic [PosN-1:0]       active_q, active_d;
  logic [PosN-1:0]       closed;
  logic [PosN-1:0]       carry_p;
  logic [PatternMax-1:0] len_mask;
  logic [PatternMax-1:0] hit;
  logic [PatternMax-1:0] stay;
  logic [PatternMax-1:0] move;

  // parallel prefix: closed[k] = active[k] | (star[k-1] & closed[k-1])
  function automatic logic [PosN-1:0] close_stars(input logic [PosN-1:0] g_in,
                                                  input logic [PosN-1:0] p_in);
    logic [PosN-1:0] g;
    logic [PosN-1:0] p;
    logic [PosN-1:0] g_n;
    logic [PosN-1:0] p_n;
    g = g_in;
    p = p_in;
    for (int d = 1; d < PosN; d = d * 2) begin
      g_n = g;
      p_n = p;
      for (int k = d; k < PosN; k++) begin
        g_n[k] = g[k] | (p[k] & g[k-d]);
        p_n[k] = p[k] & p[k-d];
      end
      g = g_n;
      p = p_n;
    end
    return g;
  endfunction

  always_comb begin
    for (int j = 0; j < PatternMax; j++) begin
      len_mask[j] = 32'(j) < 32'(pat_len_i);
    end
    carry_p = {tok_star_i & len_mask, 1'b0};
    closed  = close_stars(active_q, carry_p);
    for (int j = 0; j < PatternMax; j++) begin
      hit[j] = closed[j] & len_mask[j] &
               (tok_any_i[j] || (tok_byte_i[j] == subject_byte_i));
    end
    stay = hit & tok_star_i;
    move = hit & ~tok_star_i;
  end

  always_comb begin
    active_d = active_q;
    priority if (cmd_i.load || cmd_i.finish) begin
      active_d = PosN'(1);
    end else if (cmd_i.advance) begin
      active_d = {1'b0, stay} | {move, 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= PosN'(1);
    end else begin
      active_q <= active_d;
    end
  end

  assign verdict_o = closed[pat_len_i];

endmodule

>>> src/dot_star_pattern_matcher_top.sv
// ----------------------------------------------------------------------------
// dot_star_pattern_matcher_top
// whole-string matcher for patterns of literal or any-byte tokens with star
// ----------------------------------------------------------------------------
// an accepted end item is held in the input register until it executes; its verdict is then registered in matched_o
// throughput: one item per cycle; an end item waits only while a verdict is stalled
// the byte step and star closure are one prefix network between input and state registers
// reset: empty pattern, active position zero only, no item held, no verdict pending
// pattern tokens are undefined until loaded
`timescale 1ns / 1ps

module dot_star_pattern_matcher_top import dspm_pkg::*; #(
  parameter int unsigned PatternMax = PatternMaxDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [ActionW-1:0]     action_i,
  input  logic [TokenIndexW-1:0] token_index_i,
  input  logic [ByteW-1:0]       token_byte_i,
  input  logic                   token_any_i,
  input  logic                   token_star_i,
  input  logic                   token_final_i,
  input  logic [ByteW-1:0]       subject_byte_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   matched_o
);

  localparam int unsigned LenW = $clog2(PatternMax + 1);

  logic                   in_valid_q, in_valid_d;
  logic [ActionW-1:0]     action_q;
  logic [TokenIndexW-1:0] token_index_q;
  logic [ByteW-1:0]       token_byte_q;
  logic                   token_any_q;
  logic                   token_star_q;
  logic                   token_final_q;
  logic [ByteW-1:0]       subject_byte_q;
  logic                   out_valid_q, out_valid_d;
  logic                   matched_q;
  logic                   exec;
  logic                   in_accept;
  logic                   verdict;
  cmd_t                   cmd;

  logic [PatternMax-1:0][ByteW-1:0] tok_byte;
  logic [PatternMax-1:0]            tok_any;
  logic [PatternMax-1:0]            tok_star;
  logic [LenW-1:0]                  pat_len;

  // an end item needs a free result register
  assign exec       = in_valid_q &&
                      ((action_q != ACT_END) || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !exec;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    cmd = '0;
    unique case (action_q)
      ACT_LOAD: cmd.load    = exec;
      ACT_BYTE: cmd.advance = exec;
      ACT_END:  cmd.finish  = exec;
      default:  cmd         = '0;
    endcase
  end

  always_comb begin
    in_valid_d = in_valid_q;
    priority if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (exec) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (cmd.finish) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      action_q       <= action_i;
      token_index_q  <= token_index_i;
      token_byte_q   <= token_byte_i;
      token_any_q    <= token_any_i;
      token_star_q   <= token_star_i;
      token_final_q  <= token_final_i;
      subject_byte_q <= subject_byte_i;
    end
    if (cmd.finish) begin
      matched_q <= verdict;
    end
  end

  dspm_token_store #(
    .PatternMax (PatternMax)
  ) u_token_store (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .token_index_i (token_index_q),
    .token_byte_i  (token_byte_q),
    .token_any_i   (token_any_q),
    .token_star_i  (token_star_q),
    .token_final_i (token_final_q),
    .tok_byte_o    (tok_byte),
    .tok_any_o     (tok_any),
    .tok_star_o    (tok_star),
    .pat_len_o     (pat_len)
  );

  dspm_advance #(
    .PatternMax (PatternMax)
  ) u_advance (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .subject_byte_i (subject_byte_q),
    .tok_byte_i     (tok_byte),
    .tok_any_i      (tok_any),
    .tok_star_i     (tok_star),
    .pat_len_i      (pat_len),
    .verdict_o      (verdict)
  );

  assign out_valid_o = out_valid_q;
  assign matched_o   = matched_q;

  // a new verdict appears only from an executed end item
  a_verdict_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd.finish))
    else $error("verdict without end item");

  // a stalled verdict is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !cmd.finish)
    else $error("pending verdict overwritten");

  // the input side stalls only while it holds an item
  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && (action_q == ACT_END)))
    else $error("stall without held end item");

  // pattern length never exceeds the token store
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pat_len) <= 32'(PatternMax))
    else $error("pattern length out of range");

endmodule

>>> test/dot_star_pattern_matcher_top_test.sv
// ----------------------------------------------------------------------------
// dot_star_pattern_matcher_top_test
// self-checking bench for the dot-star pattern matcher: a queue-fed driver
// loads patterns and streams subjects under random bursts and gaps, a
// monitor under its own stall pattern checks each verdict against a
// bit-vector prediction of the active token positions
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dot_star_pattern_matcher_top_test;
  import dspm_pkg::*;

  localparam int unsigned PatternMax = PatternMaxDef;
  localparam logic [ActionW-1:0] ActUnused = 2'd3;
  localparam int RandomItems = 1550;
  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic [ActionW-1:0]     action;
    logic [TokenIndexW-1:0] tok_idx;
    logic [ByteW-1:0]       tbyte;
    logic                   any;
    logic                   star;
    logic                   fin;
    logic [ByteW-1:0]       sbyte;
  } match_item_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic [ActionW-1:0]     action_i = '0;
  logic [TokenIndexW-1:0] token_index_i = '0;
  logic [ByteW-1:0]       token_byte_i = '0;
  logic                   token_any_i = 1'b0;
  logic                   token_star_i = 1'b0;
  logic                   token_final_i = 1'b0;
  logic [ByteW-1:0]       subject_byte_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic                   matched_o;

  dot_star_pattern_matcher_top #(
    .PatternMax(PatternMax)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .token_index_i (token_index_i),
    .token_byte_i  (token_byte_i),
    .token_any_i   (token_any_i),
    .token_star_i  (token_star_i),
    .token_final_i (token_final_i),
    .subject_byte_i(subject_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .matched_o     (matched_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  match_item_t pending_items[$];
  logic        verdict_q[$];
  int          errors = 0;
  int          cycle_cnt = 0;
  int          n_items = 0;

  // predicted matcher state
  logic [ByteW-1:0]  pat_byte [PatternMax];
  logic              pat_any  [PatternMax];
  logic              pat_star [PatternMax];
  logic [5:0]        pat_len = '0;
  logic [PatternMax:0] live_pos = 1;

  // generator view of the loaded pattern
  logic [ByteW-1:0]  gen_byte [PatternMax];
  logic              gen_any  [PatternMax];
  logic              gen_star [PatternMax];
  int                gen_len = 0;
  logic [PatternMax-1:0] written = '0;

  task automatic close_stars();
    for (int j = 0; j < pat_len; j++) begin
      if (live_pos[j] && pat_star[j]) live_pos[j+1] = 1'b1;
    end
  endtask

  task automatic match_step(input match_item_t it);
    logic [PatternMax:0] nxt;
    nxt = '0;
    case (it.action)
      ACT_LOAD: begin
        pat_byte[it.tok_idx] = it.tbyte;
        pat_any[it.tok_idx]  = it.any;
        pat_star[it.tok_idx] = it.star;
        if (it.fin) pat_len = 6'(it.tok_idx) + 6'd1;
        live_pos = 1;
      end
      ACT_BYTE: begin
        close_stars();
        for (int j = 0; j < pat_len; j++) begin
          if (live_pos[j] && (pat_any[j] || pat_byte[j] == it.sbyte)) begin
            if (pat_star[j]) nxt[j] = 1'b1;
            else nxt[j+1] = 1'b1;
          end
        end
        live_pos = nxt;
      end
      ACT_END: begin
        close_stars();
        verdict_q.push_back(live_pos[pat_len]);
        live_pos = 1;
      end
      default: ;
    endcase
  endtask

  function automatic logic [ByteW-1:0] pick_byte();
    if ($urandom_range(0, 99) < 85) return 8'h61 + 8'($urandom_range(0, 2));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic push_item(input logic [ActionW-1:0] act, input int idx,
                           input logic [ByteW-1:0] tb, input logic ta, input logic ts,
                           input logic tf, input logic [ByteW-1:0] sb);
    match_item_t it;
    it.action  = act;
    it.tok_idx = TokenIndexW'(idx);
    it.tbyte   = tb;
    it.any     = ta;
    it.star    = ts;
    it.fin     = tf;
    it.sbyte   = sb;
    pending_items.push_back(it);
    if (act != ActUnused) n_items++;
  endtask

  // a final flag is only sent when every lower token has been loaded
  task automatic put_load(input int idx, input logic [ByteW-1:0] tb, input logic ta,
                          input logic ts, input logic tf);
    logic ok;
    ok = 1'b1;
    for (int j = 0; j < idx; j++) if (!written[j]) ok = 1'b0;
    if (!ok) tf = 1'b0;
    gen_byte[idx] = tb;
    gen_any[idx]  = ta;
    gen_star[idx] = ts;
    written[idx]  = 1'b1;
    if (tf) gen_len = idx + 1;
    push_item(ACT_LOAD, idx, tb, ta, ts, tf, 8'($urandom_range(0, 255)));
  endtask

  task automatic put_byte(input logic [ByteW-1:0] sb);
    push_item(ACT_BYTE, $urandom_range(0, 31), 8'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), sb);
  endtask

  task automatic put_end();
    push_item(ACT_END, $urandom_range(0, 31), 8'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
  endtask

  task automatic put_unused();
    push_item(ActUnused, $urandom_range(0, 31), 8'($urandom_range(0, 255)),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
  endtask

  task automatic new_pattern();
    int len;
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) len = $urandom_range(1, 6);
    else if (r < 95) len = $urandom_range(7, 16);
    else len = $urandom_range(17, PatternMax);
    for (int i = 0; i < len; i++) begin
      put_load(i, pick_byte(), ($urandom_range(0, 3) == 0), ($urandom_range(0, 2) == 0),
               (i == len - 1));
    end
  endtask

  // mostly a string built from the pattern, sometimes damaged
  task automatic put_subject();
    logic [ByteW-1:0] subj[$];
    int reps;
    int k;
    int r;
    for (int j = 0; j < gen_len; j++) begin
      reps = gen_star[j] ? $urandom_range(0, 3) : 1;
      for (int n = 0; n < reps; n++) subj.push_back(gen_any[j] ? pick_byte() : gen_byte[j]);
    end
    r = $urandom_range(0, 99);
    if (r < 12 && subj.size() > 0) subj[$urandom_range(0, subj.size() - 1)] = pick_byte();
    else if (r < 22 && subj.size() > 0) begin
      k = $urandom_range(0, subj.size() - 1);
      subj.delete(k);
    end else if (r < 32) subj.push_back(pick_byte());
    foreach (subj[i]) begin
      put_byte(subj[i]);
      if ($urandom_range(0, 99) < 2) put_unused();
    end
    if ($urandom_range(0, 99) < 4 && gen_len > 0) begin
      k = $urandom_range(0, gen_len - 1);
      put_load(k, pick_byte(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0);
    end
    put_end();
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid_i || verdict_q.size() != 0)
      @(negedge clk_i);
  endtask

  // driver
  int gap_left = 0;
  int burst_left = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return 0;
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    match_item_t cur;
    match_item_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      cur = {action_i, token_index_i, token_byte_i, token_any_i, token_star_i,
             token_final_i, subject_byte_i};
      if (in_valid_i && !in_stall_o) match_step(cur);
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0 || pending_items.size() == 0) begin
          if (gap_left != 0) gap_left--;
          in_valid_i <= 1'b0;
        end else begin
          nxt = pending_items.pop_front();
          action_i       <= nxt.action;
          token_index_i  <= nxt.tok_idx;
          token_byte_i   <= nxt.tbyte;
          token_any_i    <= nxt.any;
          token_star_i   <= nxt.star;
          token_final_i  <= nxt.fin;
          subject_byte_i <= nxt.sbyte;
          in_valid_i     <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = pick_gap();
          end
        end
      end
    end
  end

  // monitor
  int stall_mode = 0;
  int stall_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin : mon_proc
    logic want;
    logic ns;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected verdict, expected none, actual matched=%0b",
                   $time, matched_o);
          errors++;
        end else begin
          want = verdict_q.pop_front();
          if (matched_o !== want) begin
            $display("%0t: matched mismatch, expected %0b, actual %0b",
                     $time, want, matched_o);
            errors++;
          end
        end
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(16, 200);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0: ns = 1'b0;
        1: ns = ($urandom_range(0, 99) < 30);
        2: ns = ($urandom_range(0, 99) < 80);
        default: ns = cycle_cnt[2];
      endcase
      out_stall_i <= ns;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int r;
    logic mid_done;
    mid_done = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty pattern
    put_end();
    put_byte(8'h00);
    put_end();
    put_unused();
    // byte, any-star, byte
    put_load(0, 8'h00, 1'b0, 1'b0, 1'b0);
    put_load(1, 8'hA5, 1'b1, 1'b1, 1'b0);
    put_load(2, 8'hFF, 1'b0, 1'b0, 1'b1);
    put_byte(8'h00);
    put_byte(8'hFF);
    put_end();
    put_byte(8'h00);
    put_byte(8'h5A);
    put_byte(8'hC3);
    put_byte(8'hFF);
    put_end();
    put_end();
    // load abandons the subject in progress
    put_byte(8'h00);
    put_load(2, 8'hFF, 1'b0, 1'b0, 1'b1);
    put_end();
    put_load(31, 8'h80, 1'b1, 1'b1, 1'b0);
    // single starred literal
    put_load(0, 8'h61, 1'b0, 1'b1, 1'b1);
    put_end();
    put_byte(8'h61);
    put_byte(8'h61);
    put_end();
    put_byte(8'h62);
    put_end();
    wait_drained();

    n_items = 0;
    new_pattern();
    while (n_items < RandomItems) begin
      r = $urandom_range(0, 99);
      if (r < 14) new_pattern();
      else if (r < 86) put_subject();
      else if (r < 90) put_byte(8'($urandom_range(0, 255)));
      else if (r < 93) put_end();
      else if (r < 96) put_unused();
      else put_load($urandom_range(0, PatternMax - 1), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
      if (!mid_done && n_items > RandomItems / 2) begin
        mid_done = 1'b1;
        wait_drained();
      end
    end

    wait_drained();
    repeat (10) @(negedge clk_i);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
